FILE: rtl/recursive_packed_matrix_index_defines.svh
// Assertion macros shared by the index pipeline.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef RECURSIVE_PACKED_MATRIX_INDEX_DEFINES_SVH
`define RECURSIVE_PACKED_MATRIX_INDEX_DEFINES_SVH

// Same-cycle implication.
`define RPMI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RPMI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rpmi_pkg.sv
package rpmi_pkg;

    localparam int IDX_W         = 12;
    localparam int REG_W         = 13;
    localparam int HALF_W        = REG_W - 1;
    localparam int OFF_W         = 24;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;
    localparam int REG_SEL_BIT   = 2;
    localparam int REG_MAX       = 2 ** REG_W - 1;
    localparam int DEF_MAX_ORDER = 4096;

    localparam logic [REG_W-1:0] SIZE_RESET = REG_W'(256);
    localparam logic [REG_W-1:0] LEAF_RESET = REG_W'(64);

    typedef enum logic [0:0] {
        REG_MATRIX_SIZE = 1'b0,
        REG_LEAF_SIZE   = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        MODE_TRI    = 1'b0,
        MODE_SQUARE = 1'b1
    } blk_mode_t;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
    } req_t;

    typedef struct packed {
        logic [OFF_W-1:0] element_offset;
        logic             out_of_range;
    } rsp_t;

    typedef struct packed {
        logic             valid;
        logic             oor;
        blk_mode_t        mode;
        logic [REG_W-1:0] n;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        logic [OFF_W-1:0] base;
    } walk_t;

    typedef struct packed {
        logic [OFF_W-1:0] tri_size;
        logic [OFF_W-1:0] sq_size;
    } lvl_const_t;

endpackage

FILE: rtl/rpmi_cfg.sv
module rpmi_cfg #(
    parameter int MAX_ORDER = rpmi_pkg::DEF_MAX_ORDER,
    parameter int LEVELS    = $clog2(rpmi_pkg::DEF_MAX_ORDER)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpmi_pkg::ADDR_W-1:0]  paddr,
    input  logic [rpmi_pkg::DATA_W-1:0]  pwdata,
    output logic [rpmi_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [rpmi_pkg::REG_W-1:0]   size_eff,
    output logic [rpmi_pkg::REG_W-1:0]   leaf_eff,
    output rpmi_pkg::lvl_const_t         lconst [LEVELS]
);
    import rpmi_pkg::*;

    localparam int ORDER_CAP = (MAX_ORDER < REG_MAX) ? MAX_ORDER : REG_MAX;
    localparam logic [REG_W-1:0] CAP_N = REG_W'(ORDER_CAP);

    logic [REG_W-1:0] size_reg;
    logic [REG_W-1:0] size_next;
    logic [REG_W-1:0] leaf_reg;
    logic [REG_W-1:0] leaf_next;
    logic [REG_W-1:0] leaf_clamp;
    logic             wr;
    reg_idx_t         reg_sel;
    lvl_const_t       lconst_reg  [LEVELS];
    lvl_const_t       lconst_next [LEVELS];

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_sel = reg_idx_t'(paddr[REG_SEL_BIT]);

    always_comb
    begin
        size_next = size_reg;
        leaf_next = leaf_reg;
        if (wr)
        begin
            unique case (reg_sel)
                REG_MATRIX_SIZE: size_next = pwdata[REG_W-1:0];
                REG_LEAF_SIZE:   leaf_next = pwdata[REG_W-1:0];
                default:         size_next = size_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MATRIX_SIZE: prdata = {{(DATA_W-REG_W){1'b0}}, size_reg};
            REG_LEAF_SIZE:   prdata = {{(DATA_W-REG_W){1'b0}}, leaf_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            leaf_reg <= LEAF_RESET;
        end
        else
        begin
            size_reg <= size_next;
            leaf_reg <= leaf_next;
        end
    end

    assign size_eff   = (size_reg > CAP_N) ? CAP_N : size_reg;
    assign leaf_clamp = (leaf_reg > CAP_N) ? CAP_N : leaf_reg;
    assign leaf_eff   = (leaf_clamp == '0) ? REG_W'(1) : leaf_clamp;

    // Per-level block sizes: level k halves an order of size_eff >> k.
    for (genvar k = 0; k < LEVELS; k++)
    begin : g_lvl
        logic [HALF_W-1:0]   h;
        logic [HALF_W:0]     h_inc;
        logic [2*HALF_W:0]   tri_prod;
        logic [2*HALF_W-1:0] sq_prod;

        assign h        = HALF_W'(size_eff >> (k + 1));
        assign h_inc    = {1'b0, h} + (HALF_W + 1)'(1);
        assign tri_prod = {{HALF_W{1'b0}}, h_inc} * {{(HALF_W + 1){1'b0}}, h};
        assign sq_prod  = {{HALF_W{1'b0}}, h} * {{HALF_W{1'b0}}, h};
        assign lconst_next[k].tri_size = OFF_W'(tri_prod >> 1);
        assign lconst_next[k].sq_size  = OFF_W'(sq_prod);
    end

    always_ff @(posedge clk)
    begin
        lconst_reg <= lconst_next;
    end

    assign lconst = lconst_reg;

endmodule

FILE: rtl/rpmi_level.sv
`include "recursive_packed_matrix_index_defines.svh"

module rpmi_level (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  rpmi_pkg::walk_t             prev,
    input  rpmi_pkg::lvl_const_t        lconst,
    input  logic [rpmi_pkg::REG_W-1:0]  leaf_eff,
    output rpmi_pkg::walk_t             stage
);
    import rpmi_pkg::*;

    logic [HALF_W-1:0] h;
    logic              r_lo;
    logic              c_lo;
    logic              active;
    logic [OFF_W-1:0]  sq2;
    logic [OFF_W-1:0]  add_a;
    logic [OFF_W-1:0]  add_b;
    walk_t             data_next;
    walk_t             data_reg;
    logic              valid_reg;

    assign h      = prev.n[REG_W-1:1];
    assign r_lo   = prev.r < h;
    assign c_lo   = prev.c < h;
    assign active = prev.n > leaf_eff;
    assign sq2    = {lconst.sq_size[OFF_W-2:0], 1'b0};

    always_comb
    begin
        data_next = prev;
        add_a     = '0;
        add_b     = '0;
        if (active)
        begin
            data_next.n = {1'b0, h};
            unique case (prev.mode)
                MODE_TRI:
                begin
                    priority if (r_lo)
                    begin
                        data_next.mode = MODE_TRI;
                    end
                    else if (c_lo)
                    begin
                        add_a          = lconst.tri_size;
                        data_next.mode = MODE_SQUARE;
                        data_next.r    = prev.r - h;
                    end
                    else
                    begin
                        add_a       = lconst.tri_size;
                        add_b       = lconst.sq_size;
                        data_next.r = prev.r - h;
                        data_next.c = prev.c - h;
                    end
                end
                MODE_SQUARE:
                begin
                    unique case ({r_lo, c_lo})
                        2'b11:
                        begin
                            add_a = '0;
                        end
                        2'b01:
                        begin
                            add_a       = lconst.sq_size;
                            data_next.r = prev.r - h;
                        end
                        2'b10:
                        begin
                            add_a       = sq2;
                            data_next.c = prev.c - h;
                        end
                        default:
                        begin
                            add_a       = lconst.sq_size;
                            add_b       = sq2;
                            data_next.r = prev.r - h;
                            data_next.c = prev.c - h;
                        end
                    endcase
                end
                default:
                begin
                    data_next.mode = prev.mode;
                end
            endcase
        end
        data_next.base = prev.base + add_a + add_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

    `RPMI_ASSERT_NEXT(a_leaf_passes, en && prev.valid && !active, stage.base == $past(prev.base) && stage.n == $past(prev.n), "Item at leaf order was changed by a halving level.")
    `RPMI_ASSERT_IMPL(a_tri_lower, stage.valid && !stage.oor && stage.mode == MODE_TRI, stage.r >= stage.c, "Triangle item left the lower half.")

endmodule

FILE: rtl/rpmi_leaf.sv
module rpmi_leaf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en_prod,
    input  logic              en_out,
    input  rpmi_pkg::walk_t   prev,
    output logic              prod_valid,
    output logic              rsp_valid,
    output rpmi_pkg::rsp_t    rsp
);
    import rpmi_pkg::*;

    typedef struct packed {
        logic             oor;
        logic             is_tri;
        logic [OFF_W-1:0] bt;
        logic [OFF_W-1:0] cn;
        logic [OFF_W-1:0] cc;
    } prod_t;

    logic [IDX_W+REG_W-1:0] cn_full;
    logic [2*IDX_W-1:0]     cc_full;
    logic [IDX_W-1:0]       c_dec;
    logic [IDX_W-1:0]       term;
    prod_t                  prod_next;
    prod_t                  prod_reg;
    logic                   prod_valid_reg;
    logic [OFF_W-1:0]       sum;
    rsp_t                   rsp_next;
    rsp_t                   rsp_reg;
    logic                   rsp_valid_reg;

    // Leaf triangle is packed by columns, leaf square is column-major.
    assign c_dec   = prev.c - IDX_W'(1);
    assign cn_full = {{REG_W{1'b0}}, prev.c} * {{IDX_W{1'b0}}, prev.n};
    assign cc_full = {{IDX_W{1'b0}}, prev.c} * {{IDX_W{1'b0}}, c_dec};
    assign term    = (prev.mode == MODE_TRI) ? (prev.r - prev.c) : prev.r;

    always_comb
    begin
        prod_next.oor    = prev.oor;
        prod_next.is_tri = (prev.mode == MODE_TRI);
        prod_next.bt     = prev.base + {{(OFF_W-IDX_W){1'b0}}, term};
        prod_next.cn     = OFF_W'(cn_full);
        prod_next.cc     = OFF_W'(cc_full >> 1);
    end

    assign sum = prod_reg.bt + prod_reg.cn - (prod_reg.is_tri ? prod_reg.cc : '0);

    always_comb
    begin
        rsp_next.element_offset = prod_reg.oor ? '0 : sum;
        rsp_next.out_of_range   = prod_reg.oor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (en_prod)
            begin
                prod_valid_reg <= prev.valid;
            end
            if (en_out)
            begin
                rsp_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            prod_reg <= prod_next;
        end
        if (en_out)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

endmodule

FILE: rtl/recursive_packed_matrix_index.sv
// Address generator for a symmetric matrix held in recursive packed storage. Each item
// carries a row and a column; the result is the element offset of that entry (row and
// column swapped when the column is the larger) and an out-of-range flag, with offset zero
// when either index is not below matrix_size. One item is taken per clock unless req_stall
// is high, and results come out in order after passing one entry stage, one stage per
// possible halving of the matrix order, and two stages for the leaf multiply and the final
// sum. A stall at the output is absorbed by empty stages first, so input is refused only
// when every stage holds an item. matrix_size and leaf_size are written over the APB port
// at byte addresses 0 and 4; values above MAX_ORDER act as MAX_ORDER and a leaf size of
// zero acts as one. Write them only while the pipeline is empty; the per-level block
// sizes are recomputed in the cycle after a write.
`include "recursive_packed_matrix_index_defines.svh"

module recursive_packed_matrix_index #(
    parameter int MAX_ORDER = rpmi_pkg::DEF_MAX_ORDER
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpmi_pkg::ADDR_W-1:0]  paddr,
    input  logic [rpmi_pkg::DATA_W-1:0]  pwdata,
    output logic [rpmi_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  rpmi_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output rpmi_pkg::rsp_t               rsp
);
    import rpmi_pkg::*;

    localparam int LEVELS = $clog2(MAX_ORDER);
    localparam int STAGES = LEVELS + 3;

    logic [REG_W-1:0] size_eff;
    logic [REG_W-1:0] leaf_eff;
    lvl_const_t       lconst [LEVELS];
    walk_t            walk   [LEVELS+1];
    logic [STAGES-1:0] stage_valid;
    logic [STAGES-1:0] ready;
    logic             prod_valid;
    logic             entry_oor;
    logic             entry_swap;
    walk_t            entry_next;
    walk_t            entry_reg;
    logic             entry_valid_reg;

    rpmi_cfg #(
        .MAX_ORDER (MAX_ORDER),
        .LEVELS    (LEVELS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .size_eff (size_eff),
        .leaf_eff (leaf_eff),
        .lconst   (lconst)
    );

    assign entry_oor  = ({1'b0, req.row_index} >= size_eff) ||
                        ({1'b0, req.col_index} >= size_eff);
    assign entry_swap = req.col_index > req.row_index;

    always_comb
    begin
        entry_next.valid = req_valid;
        entry_next.oor   = entry_oor;
        entry_next.mode  = MODE_TRI;
        entry_next.n     = size_eff;
        entry_next.r     = entry_swap ? req.col_index : req.row_index;
        entry_next.c     = entry_swap ? req.row_index : req.col_index;
        entry_next.base  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (ready[0])
        begin
            entry_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            entry_reg <= entry_next;
        end
    end

    assign walk[0] = '{
        valid: entry_valid_reg,
        oor:   entry_reg.oor,
        mode:  entry_reg.mode,
        n:     entry_reg.n,
        r:     entry_reg.r,
        c:     entry_reg.c,
        base:  entry_reg.base
    };

    for (genvar k = 0; k < LEVELS; k++)
    begin : g_level
        rpmi_level u_level (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (ready[k+1]),
            .prev     (walk[k]),
            .lconst   (lconst[k]),
            .leaf_eff (leaf_eff),
            .stage    (walk[k+1])
        );
    end

    rpmi_leaf u_leaf (
        .clk        (clk),
        .rst_n      (rst_n),
        .en_prod    (ready[LEVELS+1]),
        .en_out     (ready[LEVELS+2]),
        .prev       (walk[LEVELS]),
        .prod_valid (prod_valid),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp)
    );

    for (genvar i = 0; i <= LEVELS; i++)
    begin : g_valid
        assign stage_valid[i] = walk[i].valid;
    end
    assign stage_valid[LEVELS+1] = prod_valid;
    assign stage_valid[LEVELS+2] = rsp_valid;

    // A stage loads when it is empty or its item moves on in the same cycle.
    assign ready[STAGES-1] = !rsp_valid || !rsp_stall;
    for (genvar i = 0; i < STAGES - 1; i++)
    begin : g_ready
        assign ready[i] = !stage_valid[i] || ready[i+1];
    end

    assign req_stall = !ready[0];

    `RPMI_ASSERT_NEXT(a_entry_oor,
        req_valid && !req_stall && entry_oor,
        walk[0].valid && walk[0].oor,
        "Out-of-range item lost its flag at entry.")
    `RPMI_ASSERT_IMPL(a_stall_source,
        req_stall,
        rsp_valid && rsp_stall && (&stage_valid),
        "Input refused while the pipeline still had room.")

endmodule

FILE: test/recursive_packed_matrix_index_check.sv
`timescale 1ns / 1ps

module recursive_packed_matrix_index_check
    import rpmi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              req_valid,
    input  logic              req_stall,
    input  req_t              req,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  rsp_t              rsp,
    output int                mismatches,
    output int                outstanding,
    output int                checked,
    output int                flagged
);

    localparam int ORDER_LIMIT = DEF_MAX_ORDER;

    logic [REG_W-1:0] size_copy;
    logic [REG_W-1:0] leaf_copy;
    rsp_t             offset_queue[$];

    function automatic rsp_t entry_offset(req_t item, logic [REG_W-1:0] size_reg,
                                          logic [REG_W-1:0] leaf_reg);
        longint unsigned n;
        longint unsigned leaf;
        longint unsigned r;
        longint unsigned c;
        longint unsigned h;
        longint unsigned swap_tmp;
        longint unsigned base;
        longint unsigned tri_sz;
        longint unsigned sq_sz;
        longint unsigned off;
        blk_mode_t       mode;
        rsp_t            result;

        n = size_reg;
        if (n > ORDER_LIMIT)
            n = ORDER_LIMIT;
        leaf = leaf_reg;
        if (leaf > ORDER_LIMIT)
            leaf = ORDER_LIMIT;
        if (leaf == 0)
            leaf = 1;
        r = item.row_index;
        c = item.col_index;
        if (r >= n || c >= n)
        begin
            result.element_offset = '0;
            result.out_of_range = 1'b1;
            return result;
        end
        if (c > r)
        begin
            swap_tmp = r;
            r = c;
            c = swap_tmp;
        end
        base = 0;
        mode = MODE_TRI;
        while (n > leaf)
        begin
            h = n / 2;
            tri_sz = h * (h + 1) / 2;
            sq_sz = h * h;
            if (mode == MODE_TRI)
            begin
                if (r >= h && c < h)
                begin
                    // The entry sits in the square block below the top triangle.
                    base += tri_sz;
                    r -= h;
                    mode = MODE_SQUARE;
                end
                else if (r >= h)
                begin
                    base += tri_sz + sq_sz;
                    r -= h;
                    c -= h;
                end
            end
            else
            begin
                if (r >= h && c < h)
                begin
                    base += sq_sz;
                    r -= h;
                end
                else if (r < h && c >= h)
                begin
                    base += 2 * sq_sz;
                    c -= h;
                end
                else if (r >= h)
                begin
                    base += 3 * sq_sz;
                    r -= h;
                    c -= h;
                end
            end
            n = h;
        end
        if (mode == MODE_TRI)
            off = base + c * n - (c * (c - 1)) / 2 + (r - c);
        else
            off = base + c * n + r;
        result.element_offset = off[OFF_W-1:0];
        result.out_of_range = 1'b0;
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        rsp_t want;
        logic bad;

        if (!rst_n)
        begin
            size_copy <= SIZE_RESET;
            leaf_copy <= LEAF_RESET;
            offset_queue.delete();
            mismatches <= 0;
            outstanding <= 0;
            checked <= 0;
            flagged <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (reg_idx_t'(paddr[REG_SEL_BIT]) == REG_MATRIX_SIZE)
                    size_copy <= pwdata[REG_W-1:0];
                else
                    leaf_copy <= pwdata[REG_W-1:0];
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (offset_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, offset %0d flag %0b", $time,
                             rsp.element_offset, rsp.out_of_range);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = offset_queue.pop_front();
                    bad = 1'b0;
                    if (rsp.element_offset !== want.element_offset)
                    begin
                        $display("%0t: element_offset expected %0d, got %0d", $time,
                                 want.element_offset, rsp.element_offset);
                        bad = 1'b1;
                    end
                    if (rsp.out_of_range !== want.out_of_range)
                    begin
                        $display("%0t: out_of_range expected %0b, got %0b", $time,
                                 want.out_of_range, rsp.out_of_range);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches <= mismatches + 1;
                    if (want.out_of_range)
                        flagged <= flagged + 1;
                    checked <= checked + 1;
                end
            end
            if (req_valid && !req_stall)
                offset_queue.push_back(entry_offset(req, size_copy, leaf_copy));
            outstanding <= offset_queue.size();
        end
    end

endmodule

FILE: test/recursive_packed_matrix_index_test.sv
`timescale 1ns / 1ps

module recursive_packed_matrix_index_test;
    import rpmi_pkg::*;

    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 115;
    localparam int FIRST_COUNT = 19;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              req_valid;
    logic              req_stall;
    req_t              req;
    logic              rsp_valid;
    logic              rsp_stall;
    rsp_t              rsp;
    int                mismatches;
    int                outstanding;
    int                checked;
    int                flagged;
    int                sent;
    bit                quiet;

    logic [2*IDX_W-1:0] first_pairs [FIRST_COUNT] = '{
        {12'd0, 12'd0}, {12'd255, 12'd255}, {12'd255, 12'd0}, {12'd0, 12'd255},
        {12'd4095, 12'd4095}, {12'd4095, 12'd0}, {12'd0, 12'd4095}, {12'd256, 12'd0},
        {12'd0, 12'd256}, {12'd255, 12'd256}, {12'd128, 12'd127}, {12'd127, 12'd128},
        {12'd128, 12'd128}, {12'd64, 12'd63}, {12'd63, 12'd64}, {12'd200, 12'd130},
        {12'd191, 12'd64}, {12'd2730, 12'd1365}, {12'd1365, 12'd2730}
    };

    logic [REG_W-1:0] phase_size [PHASES] = '{
        13'd4096, 13'd8191, 13'd4096, 13'd0, 13'd1, 13'd100, 13'd1000, 13'd512, 13'd37
    };
    logic [REG_W-1:0] phase_leaf [PHASES] = '{
        13'd1, 13'd0, 13'd4096, 13'd64, 13'd1, 13'd3, 13'd8191, 13'd16, 13'd2
    };

    recursive_packed_matrix_index uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    recursive_packed_matrix_index_check offset_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .flagged     (flagged)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2400000;
        $display("recursive_packed_matrix_index_test: FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 22);
    end

    function automatic logic [IDX_W-1:0] pick_index(int order);
        int roll;

        roll = $urandom_range(0, 99);
        if (order > 0 && roll < 70)
            return IDX_W'($urandom_range(0, order - 1));
        if (roll < 85)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return IDX_W'(order - 1);
                2: return IDX_W'(order);
                default: return '1;
            endcase
        end
        return IDX_W'($urandom);
    endfunction

    task automatic write_reg(reg_idx_t which, logic [REG_W-1:0] value);
        bit ready;

        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            ready = pready;
            @(posedge clk);
        end
        while (!ready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_index(req_t item);
        bit stalled;

        while (!quiet && $urandom_range(0, 99) < 22)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
        begin
            @(negedge clk);
            stalled = req_stall;
            @(posedge clk);
        end
        while (stalled);
        sent++;
    endtask

    initial
    begin : stimulus
        int k;
        int p;
        int order;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_valid = 1'b0;
        req = '0;
        quiet = 1'b0;
        sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < FIRST_COUNT; k++)
            send_index(req_t'(first_pairs[k]));
        req_valid <= 1'b0;

        for (p = 0; p < PHASES; p++)
        begin
            do @(negedge clk); while (outstanding != 0);
            repeat (20) @(posedge clk);
            write_reg(REG_MATRIX_SIZE, phase_size[p]);
            write_reg(REG_LEAF_SIZE, phase_leaf[p]);
            repeat (2) @(posedge clk);
            order = (phase_size[p] > DEF_MAX_ORDER) ? DEF_MAX_ORDER : phase_size[p];
            quiet <= (p == 2);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_index({pick_index(order), pick_index(order)});
            req_valid <= 1'b0;
        end
        quiet <= 1'b0;

        for (k = 0; k < 5000 && outstanding != 0; k++)
            @(negedge clk);
        repeat (30) @(posedge clk);
        if (outstanding != 0)
            $display("%0t: %0d expected results never arrived", $time, outstanding);
        $display("Sent %0d index pairs across %0d register settings; %0d results checked,",
                 sent, PHASES + 1, checked);
        $display("%0d of them flagged out of range.", flagged);
        if (mismatches == 0 && outstanding == 0)
            $display("recursive_packed_matrix_index_test: PASS");
        else
            $display("recursive_packed_matrix_index_test: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rpmi_pkg.sv
rtl/rpmi_cfg.sv
rtl/rpmi_level.sv
rtl/rpmi_leaf.sv
rtl/recursive_packed_matrix_index.sv
test/recursive_packed_matrix_index_check.sv
test/recursive_packed_matrix_index_test.sv
